>>> src/ewo_pkg.sv
package ewo_pkg;

	localparam int WC_W       = 15;
	localparam int GAIN_W     = 32;
	localparam int RIGHT_W    = 16;
	localparam int MAG_W      = 16;
	localparam int PROD_W     = GAIN_W + MAG_W;
	localparam int OUT_W      = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int STEP_W     = 6;

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_LINEAR  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_ANGULAR = 2'd2;

	localparam logic [WC_W-1:0]   WINDOW_COUNT_RST = 15'd20;
	localparam logic [GAIN_W-1:0] GAIN_LINEAR_RST  = 32'd2720000;
	localparam logic [GAIN_W-1:0] GAIN_ANGULAR_RST = 32'd12952000;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} seq_state_t;

	typedef struct packed {
		logic [MAG_W-1:0] mag_lin;
		logic             neg_lin;
		logic [MAG_W-1:0] mag_ang;
		logic             neg_ang;
	} job_t;

	function automatic logic [OUT_W-1:0] saturate(input logic [PROD_W-1:0] q, input logic neg);
		logic big;
		logic [OUT_W-1:0] res;
		big = (q[PROD_W-1:OUT_W-1] != '0);
		if (neg) begin
			res = big ? {1'b1, {(OUT_W-1){1'b0}}} : (~q[OUT_W-1:0]) + OUT_W'(1);
		end else begin
			res = big ? {1'b0, {(OUT_W-1){1'b1}}} : q[OUT_W-1:0];
		end
		return res;
	endfunction

endpackage

>>> src/ewo_in_if.sv
interface ewo_in_if;
	logic               valid;
	logic               ready;
	logic               pin_a;
	logic               pin_b;
	logic signed [15:0] right_count;

	modport source (output valid, output pin_a, output pin_b, output right_count, input ready);
	modport sink (input valid, input pin_a, input pin_b, input right_count, output ready);
endinterface

>>> src/ewo_out_if.sv
interface ewo_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] linear_velocity;
	logic signed [31:0] angular_velocity;
	logic        [31:0] window_ticks;

	modport source (output valid, output linear_velocity, output angular_velocity,
		output window_ticks, input ready);
	modport sink (input valid, input linear_velocity, input angular_velocity,
		input window_ticks, output ready);
endinterface

>>> src/ewo_cfg_if.sv
interface ewo_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/encoder_window_odometry.sv
// Differential-drive odometry from a quadrature encoder, measured over windows
// of left-wheel counts. Each transaction on the samples channel is one sample
// tick with the A and B pin levels and the right wheel's signed count.
// Ticks that do not end a window are taken at one per cycle while idle. A tick
// that ends a window starts one shared adder that runs a shift-add multiply
// and a restoring divide for each velocity, 16 + 48 steps per velocity. The
// samples channel is not ready until both velocities are done and the result
// has been loaded into the output register that drives the results channel.
// The result sits in an output register; samples are accepted again while it
// waits, and if the receiver stalls, the next finished window waits in the
// sequencer until the register is free.
// The cfg channel is always ready and should be written only while idle.
// Reset clears the decoder state and the counts and loads the cfg defaults.
module encoder_window_odometry #(
	parameter int COUNT_WIDTH = 16,
	parameter int TIME_WIDTH  = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	ewo_in_if.sink   samples,
	ewo_out_if.source results,
	ewo_cfg_if.sink  cfg
);

	logic [ewo_pkg::WC_W-1:0]   window_count_q;
	logic [ewo_pkg::GAIN_W-1:0] gain_linear_q;
	logic [ewo_pkg::GAIN_W-1:0] gain_angular_q;
	logic                       start;
	logic                       idle;
	ewo_pkg::job_t              job;
	logic [TIME_WIDTH-1:0]      ticks;
	logic [ewo_pkg::OUT_W-1:0]  out_lin, out_ang, out_ticks;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_count_q <= ewo_pkg::WINDOW_COUNT_RST;
			gain_linear_q  <= ewo_pkg::GAIN_LINEAR_RST;
			gain_angular_q <= ewo_pkg::GAIN_ANGULAR_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				ewo_pkg::CFG_WINDOW_COUNT: window_count_q <= cfg.data[ewo_pkg::WC_W-1:0];
				ewo_pkg::CFG_GAIN_LINEAR:  gain_linear_q  <= cfg.data;
				ewo_pkg::CFG_GAIN_ANGULAR: gain_angular_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign samples.ready = idle;

	ewo_tracker #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.TIME_WIDTH  (TIME_WIDTH)
	) u_tracker (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (samples.valid && idle),
		.pin_a        (samples.pin_a),
		.pin_b        (samples.pin_b),
		.right_count  (samples.right_count),
		.window_count (window_count_q),
		.start        (start),
		.job          (job),
		.ticks        (ticks)
	);

	ewo_seq #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.job          (job),
		.ticks        (ticks),
		.gain_linear  (gain_linear_q),
		.gain_angular (gain_angular_q),
		.idle         (idle),
		.out_valid    (results.valid),
		.out_ready    (results.ready),
		.out_lin      (out_lin),
		.out_ang      (out_ang),
		.out_ticks    (out_ticks)
	);

	assign results.linear_velocity  = $signed(out_lin);
	assign results.angular_velocity = $signed(out_ang);
	assign results.window_ticks     = out_ticks;

endmodule

>>> src/ewo_alu.sv
module ewo_alu #(
	parameter int W = 33
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic         sub,
	output logic [W-1:0] sum,
	output logic         carry
);

	logic [W:0] full;

	assign full  = {1'b0, a} + {1'b0, (sub ? ~b : b)} + (W + 1)'(sub);
	assign sum   = full[W-1:0];
	assign carry = full[W];

endmodule

>>> src/ewo_tracker.sv
module ewo_tracker #(
	parameter int COUNT_WIDTH = 16,
	parameter int TIME_WIDTH  = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 accept,
	input  logic                                 pin_a,
	input  logic                                 pin_b,
	input  logic signed [ewo_pkg::RIGHT_W-1:0]   right_count,
	input  logic        [ewo_pkg::WC_W-1:0]      window_count,
	output logic                                 start,
	output ewo_pkg::job_t                        job,
	output logic        [TIME_WIDTH-1:0]         ticks
);

	localparam int EW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

	logic                   b_before_q, b_during_q, pulse_seen_q;
	logic                   b_before_d, b_during_d, pulse_seen_d;
	logic [COUNT_WIDTH-1:0] left_q, left_d;
	logic [TIME_WIDTH-1:0]  elapsed_q, elapsed_d;
	logic [EW-1:0]          left_ext;
	logic                   match;
	logic signed [16:0]     wc_s, r_s, n_lin, n_ang;
	logic [16:0]            neg_lin, neg_ang;

	always_comb begin
		b_before_d   = b_before_q;
		b_during_d   = b_during_q;
		pulse_seen_d = pulse_seen_q;
		left_d       = left_q;
		if (pin_a) begin
			if (pulse_seen_q) begin
				if (!b_before_q && b_during_q) begin
					left_d = left_q + COUNT_WIDTH'(1);
				end else if (b_before_q && !b_during_q) begin
					left_d = left_q - COUNT_WIDTH'(1);
				end
				pulse_seen_d = 1'b0;
			end
			b_before_d = pin_b;
		end else begin
			b_during_d   = pin_b;
			pulse_seen_d = 1'b1;
		end
	end

	assign elapsed_d = (&elapsed_q) ? elapsed_q : elapsed_q + TIME_WIDTH'(1);
	assign left_ext  = EW'($signed(left_d));
	assign match     = (left_ext == EW'(window_count));
	assign start     = accept && match;
	assign ticks     = elapsed_d;

	assign wc_s    = $signed({2'b00, window_count});
	assign r_s     = $signed({right_count[ewo_pkg::RIGHT_W-1], right_count});
	assign n_lin   = r_s + wc_s;
	assign n_ang   = r_s - wc_s;
	assign neg_lin = -n_lin;
	assign neg_ang = -n_ang;

	assign job.neg_lin = n_lin[16];
	assign job.mag_lin = n_lin[16] ? neg_lin[15:0] : n_lin[15:0];
	assign job.neg_ang = n_ang[16];
	assign job.mag_ang = n_ang[16] ? neg_ang[15:0] : n_ang[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_before_q   <= 1'b0;
			b_during_q   <= 1'b0;
			pulse_seen_q <= 1'b0;
			left_q       <= '0;
			elapsed_q    <= '0;
		end else if (accept) begin
			b_before_q   <= b_before_d;
			b_during_q   <= b_during_d;
			pulse_seen_q <= pulse_seen_d;
			if (match) begin
				left_q    <= '0;
				elapsed_q <= '0;
			end else begin
				left_q    <= left_d;
				elapsed_q <= elapsed_d;
			end
		end
	end

endmodule

>>> src/ewo_seq.sv
module ewo_seq #(
	parameter int TIME_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  ewo_pkg::job_t                     job,
	input  logic [TIME_WIDTH-1:0]             ticks,
	input  logic [ewo_pkg::GAIN_W-1:0]        gain_linear,
	input  logic [ewo_pkg::GAIN_W-1:0]        gain_angular,
	output logic                              idle,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ewo_pkg::OUT_W-1:0]         out_lin,
	output logic [ewo_pkg::OUT_W-1:0]         out_ang,
	output logic [ewo_pkg::OUT_W-1:0]         out_ticks
);

	localparam int TW = TIME_WIDTH;
	localparam int GW = ewo_pkg::GAIN_W;
	localparam int PW = ewo_pkg::PROD_W;
	localparam int MW = ewo_pkg::MAG_W;
	localparam int OW = ewo_pkg::OUT_W;
	localparam int SW = ewo_pkg::STEP_W;
	localparam int AW = (TW + 1 > GW + 1) ? TW + 1 : GW + 1;
	localparam logic [SW-1:0] MUL_LAST = SW'(MW - 1);
	localparam logic [SW-1:0] DIV_LAST = SW'(PW - 1);

	ewo_pkg::seq_state_t state_q, state_d;
	logic [SW-1:0]       cnt_q;
	logic                op_q;
	logic                out_valid_q;
	logic                load_out;
	ewo_pkg::job_t       job_q;
	logic [TW-1:0]       ticks_q;
	logic [PW-1:0]       p_q;
	logic [TW-1:0]       rem_q;
	logic [OW-1:0]       lin_q, ang_q;
	logic [OW-1:0]       out_lin_q, out_ang_q, out_ticks_q;
	logic [TW:0]         trial;
	logic [PW-1:0]       q_nx;
	logic [GW-1:0]       gain_sel;
	logic [AW-1:0]       alu_a, alu_b, alu_sum;
	logic                alu_sub, alu_carry;

	ewo_alu #(.W(AW)) u_alu (
		.a     (alu_a),
		.b     (alu_b),
		.sub   (alu_sub),
		.sum   (alu_sum),
		.carry (alu_carry)
	);

	assign trial    = {rem_q, p_q[PW-1]};
	assign q_nx     = {p_q[PW-2:0], alu_carry};
	assign gain_sel = op_q ? gain_angular : gain_linear;

	always_comb begin
		state_d  = state_q;
		alu_a    = '0;
		alu_b    = '0;
		alu_sub  = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ewo_pkg::ST_IDLE: begin
				if (start) begin
					state_d = ewo_pkg::ST_MUL;
				end
			end
			ewo_pkg::ST_MUL: begin
				alu_a = AW'(p_q[PW-1:MW]);
				alu_b = p_q[0] ? AW'(gain_sel) : '0;
				if (cnt_q == MUL_LAST) begin
					state_d = ewo_pkg::ST_DIV;
				end
			end
			ewo_pkg::ST_DIV: begin
				alu_a   = AW'(trial);
				alu_b   = AW'(ticks_q);
				alu_sub = 1'b1;
				if (cnt_q == DIV_LAST) begin
					state_d = op_q ? ewo_pkg::ST_DONE : ewo_pkg::ST_MUL;
				end
			end
			ewo_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ewo_pkg::ST_IDLE;
				end
			end
			default: state_d = ewo_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ewo_pkg::ST_IDLE;
			cnt_q       <= '0;
			op_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? '0 : cnt_q + SW'(1);
			if (state_q == ewo_pkg::ST_IDLE && start) begin
				op_q <= 1'b0;
			end else if (state_q == ewo_pkg::ST_DIV && cnt_q == DIV_LAST) begin
				op_q <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ewo_pkg::ST_IDLE: begin
				if (start) begin
					job_q   <= job;
					ticks_q <= ticks;
					p_q     <= PW'(job.mag_lin);
				end
			end
			ewo_pkg::ST_MUL: begin
				p_q   <= {alu_sum[GW:0], p_q[MW-1:1]};
				rem_q <= '0;
			end
			ewo_pkg::ST_DIV: begin
				rem_q <= alu_carry ? alu_sum[TW-1:0] : trial[TW-1:0];
				if (cnt_q == DIV_LAST && !op_q) begin
					lin_q <= ewo_pkg::saturate(q_nx, job_q.neg_lin);
					p_q   <= PW'(job_q.mag_ang);
				end else begin
					p_q <= q_nx;
				end
				if (cnt_q == DIV_LAST && op_q) begin
					ang_q <= ewo_pkg::saturate(q_nx, job_q.neg_ang);
				end
			end
			ewo_pkg::ST_DONE: begin
				if (load_out) begin
					out_lin_q   <= lin_q;
					out_ang_q   <= ang_q;
					out_ticks_q <= ((ticks_q >> OW) != '0) ? {OW{1'b1}} : OW'(ticks_q);
				end
			end
			default: ;
		endcase
	end

	assign idle      = (state_q == ewo_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_lin   = out_lin_q;
	assign out_ang   = out_ang_q;
	assign out_ticks = out_ticks_q;

endmodule

>>> tb/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE_CYCLES = 160;
	localparam int STALL_LIMIT   = 4000;
	localparam int SWEEP_STEPS   = 8;

	typedef struct {
		logic               pin_a;
		logic               pin_b;
		logic signed [15:0] right_count;
		bit                 hold;
	} tick_t;

	typedef struct {
		logic signed [31:0] linear_velocity;
		logic signed [31:0] angular_velocity;
		logic        [31:0] window_ticks;
	} velocity_rec_t;

	logic clk;
	logic arst_n;

	ewo_in_if  samples_if ();
	ewo_out_if results_if ();
	ewo_cfg_if cfg_if ();

	encoder_window_odometry uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.results (results_if),
		.cfg     (cfg_if)
	);

	tick_t         tick_queue[$];
	velocity_rec_t window_results_q[$];
	tick_t         next_tick;
	velocity_rec_t seen_rec;

	int send_idle = 0;
	int recv_idle = 0;
	int errors = 0;
	int stall_cycles = 0;
	bit hold_pending = 0;
	logic gen_before = 0;

	logic [ewo_pkg::WC_W-1:0]   window_q   = ewo_pkg::WINDOW_COUNT_RST;
	logic [ewo_pkg::GAIN_W-1:0] gain_lin_q = ewo_pkg::GAIN_LINEAR_RST;
	logic [ewo_pkg::GAIN_W-1:0] gain_ang_q = ewo_pkg::GAIN_ANGULAR_RST;

	logic               before_q  = 1'b0;
	logic               during_q  = 1'b0;
	logic               pulse_q   = 1'b0;
	logic signed [15:0] left_q    = '0;
	logic        [31:0] elapsed_q = '0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [31:0] scaled_velocity(input logic [31:0] gain,
			input logic signed [17:0] n, input logic [31:0] ticks);
		logic [17:0] mag;
		logic [63:0] q;
		mag = (n < 0) ? 18'(-n) : 18'(n);
		q = (64'(gain) * 64'(mag)) / 64'(ticks);
		if (n < 0) begin
			return (q >= 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - q);
		end
		return (q > 64'h7fff_ffff) ? 32'h7fff_ffff : q[31:0];
	endfunction

	function automatic void odometry_step(input logic a, input logic b,
			input logic signed [15:0] right);
		logic signed [17:0] sum_lr;
		logic signed [17:0] diff_rl;
		logic        [31:0] ticks;
		velocity_rec_t rec;
		if (a) begin
			if (pulse_q) begin
				if (!before_q && during_q) begin
					left_q = left_q + 16'sd1;
				end else if (before_q && !during_q) begin
					left_q = left_q - 16'sd1;
				end
				pulse_q = 1'b0;
			end
			before_q = b;
		end else begin
			during_q = b;
			pulse_q = 1'b1;
		end
		if (elapsed_q != '1) begin
			elapsed_q = elapsed_q + 32'd1;
		end
		if (left_q == $signed({1'b0, window_q})) begin
			ticks = (elapsed_q == 0) ? 32'd1 : elapsed_q;
			sum_lr = 18'(left_q) + 18'(right);
			diff_rl = 18'(right) - 18'(left_q);
			rec.linear_velocity = scaled_velocity(gain_lin_q, sum_lr, ticks);
			rec.angular_velocity = scaled_velocity(gain_ang_q, diff_rl, ticks);
			rec.window_ticks = ticks;
			window_results_q.push_back(rec);
			left_q = '0;
			elapsed_q = '0;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (samples_if.valid && samples_if.ready) begin
				odometry_step(samples_if.pin_a, samples_if.pin_b, samples_if.right_count);
			end
			if (!samples_if.valid || samples_if.ready) begin
				if (tick_queue.size() != 0 && !(tick_queue[0].hold && window_results_q.size() != 0)
						&& $urandom_range(99) >= send_idle) begin
					next_tick = tick_queue.pop_front();
					samples_if.valid <= 1'b1;
					samples_if.pin_a <= next_tick.pin_a;
					samples_if.pin_b <= next_tick.pin_b;
					samples_if.right_count <= next_tick.right_count;
				end else begin
					samples_if.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (results_if.valid && results_if.ready) begin
				if (window_results_q.size() == 0) begin
					$error("results transaction with no window pending");
					errors++;
				end else begin
					seen_rec = window_results_q.pop_front();
					if (results_if.linear_velocity !== seen_rec.linear_velocity) begin
						$error("linear_velocity: expected %0d, got %0d",
							seen_rec.linear_velocity, results_if.linear_velocity);
						errors++;
					end
					if (results_if.angular_velocity !== seen_rec.angular_velocity) begin
						$error("angular_velocity: expected %0d, got %0d",
							seen_rec.angular_velocity, results_if.angular_velocity);
						errors++;
					end
					if (results_if.window_ticks !== seen_rec.window_ticks) begin
						$error("window_ticks: expected %0d, got %0d",
							seen_rec.window_ticks, results_if.window_ticks);
						errors++;
					end
				end
			end
			results_if.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((samples_if.valid && samples_if.ready) || (results_if.valid && results_if.ready)
					|| (cfg_if.valid && cfg_if.ready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	function automatic logic signed [15:0] rand_right();
		case ($urandom_range(9))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2, 3, 4: return 16'($urandom);
			default: return 16'($urandom_range(0, 255)) - 16'sd128;
		endcase
	endfunction

	function automatic void push_tick(input logic a, input logic b,
			input logic signed [15:0] right);
		tick_t t;
		t.pin_a = a;
		t.pin_b = b;
		t.right_count = right;
		t.hold = hold_pending;
		hold_pending = 0;
		tick_queue.push_back(t);
	endfunction

	// One encoder pulse that moves the left count by dir, with random
	// pulse length and random B levels where they do not matter.
	function automatic void push_motion(input int dir);
		int lows;
		int highs;
		logic b;
		if (dir > 0 && gen_before) begin
			push_tick(1'b1, 1'b0, rand_right());
			gen_before = 1'b0;
		end else if (dir < 0 && !gen_before) begin
			push_tick(1'b1, 1'b1, rand_right());
			gen_before = 1'b1;
		end
		lows = $urandom_range(1, 3);
		for (int i = 1; i < lows; i++) begin
			push_tick(1'b0, 1'($urandom_range(1)), rand_right());
		end
		push_tick(1'b0, (dir > 0) ? 1'b1 : (dir < 0) ? 1'b0 : gen_before, rand_right());
		highs = $urandom_range(1, 2);
		for (int i = 0; i < highs; i++) begin
			b = 1'($urandom_range(1));
			push_tick(1'b1, b, rand_right());
			gen_before = b;
		end
	endfunction

	function automatic void push_noise();
		int n;
		logic b;
		n = $urandom_range(1, 4);
		for (int i = 0; i < n; i++) begin
			push_tick(1'($urandom_range(1)), 1'($urandom_range(1)), rand_right());
		end
		b = 1'($urandom_range(1));
		push_tick(1'b1, b, rand_right());
		gen_before = b;
	endfunction

	task automatic write_register(input logic [ewo_pkg::CFG_IDX_W-1:0] idx,
			input logic [ewo_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= val;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		cfg_if.valid <= 1'b0;
		case (idx)
			ewo_pkg::CFG_WINDOW_COUNT: window_q = val[ewo_pkg::WC_W-1:0];
			ewo_pkg::CFG_GAIN_LINEAR: gain_lin_q = val;
			ewo_pkg::CFG_GAIN_ANGULAR: gain_ang_q = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (tick_queue.size() != 0 || samples_if.valid || window_results_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		logic [ewo_pkg::WC_W-1:0] wc;
		int roll;
		samples_if.valid = 1'b0;
		samples_if.pin_a = 1'b0;
		samples_if.pin_b = 1'b0;
		samples_if.right_count = '0;
		results_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle = 35;
		recv_idle = 63;
		write_register(ewo_pkg::CFG_WINDOW_COUNT, 32'd2);
		push_tick(1, 1, 0); push_tick(0, 0, 0); push_tick(0, 1, 0);
		push_tick(1, 0, 0); push_tick(0, 1, 0); push_tick(1, 1, 0);
		push_tick(0, 0, 0); push_tick(1, 1, 0); push_tick(0, 0, 0);
		push_tick(1, 1, 0); push_tick(0, 0, 0); push_tick(1, 0, 0);
		push_tick(0, 1, 0); push_tick(1, 0, 0); push_tick(0, 1, 0);
		push_tick(1, 0, 0); push_tick(0, 1, 0); push_tick(1, 0, 0);
		push_tick(0, 1, 0); push_tick(1, 0, 16'sh7fff);
		// The sender waits here until the window that just closed has been reported.
		hold_pending = 1;
		push_tick(0, 1, 16'sh8000); push_tick(1, 0, 16'sh8000);
		push_tick(0, 1, 16'sh8000); push_tick(1, 0, 16'sh8000);
		wait_idle();

		// With a zero window every tick at a zero left count closes a window.
		write_register(ewo_pkg::CFG_WINDOW_COUNT, 32'd0);
		push_tick(1, 0, 16'sh7fff); push_tick(0, 1, 16'sh8000); push_tick(1, 1, -16'sd1);
		push_tick(0, 0, 16'sd5); push_tick(1, 0, 16'sd0);
		wait_idle();

		write_register(ewo_pkg::CFG_WINDOW_COUNT, 32'd1);
		write_register(ewo_pkg::CFG_GAIN_LINEAR, '1);
		write_register(ewo_pkg::CFG_GAIN_ANGULAR, '1);
		push_tick(0, 1, 16'sh7fff); push_tick(1, 0, 16'sh7fff);
		push_tick(0, 1, 16'sh8000); push_tick(1, 0, 16'sh8000);
		wait_idle();

		// Walk the left count into the negative range and back up again;
		// a negative count never closes a window.
		write_register(ewo_pkg::CFG_WINDOW_COUNT, 32'd32767);
		write_register(ewo_pkg::CFG_GAIN_LINEAR, 32'd2720000);
		push_tick(1, 1, rand_right());
		for (int i = 0; i < SWEEP_STEPS; i++) begin
			push_tick(0, 0, rand_right());
			push_tick(1, 1, rand_right());
		end
		push_tick(1, 0, rand_right());
		for (int i = 0; i < SWEEP_STEPS; i++) begin
			push_tick(0, 1, rand_right());
			push_tick(1, 0, rand_right());
		end
		gen_before = 1'b0;
		wait_idle();

		for (int p = 0; p < 6; p++) begin
			case (p / 2)
				0: begin
					send_idle = 35;
					recv_idle = 63;
				end
				1: begin
					send_idle = 63;
					recv_idle = 35;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			wait_idle();
			wc = (left_q > 0) ? ewo_pkg::WC_W'(left_q) + ewo_pkg::WC_W'($urandom_range(1, 2))
				: ewo_pkg::WC_W'($urandom_range(1, 2));
			write_register(ewo_pkg::CFG_WINDOW_COUNT, 32'(wc));
			write_register(ewo_pkg::CFG_GAIN_LINEAR,
				(p == 3) ? '1 : (p == 4) ? '0 : $urandom >> $urandom_range(0, 16));
			write_register(ewo_pkg::CFG_GAIN_ANGULAR,
				(p == 3) ? '0 : (p == 4) ? '1 : $urandom >> $urandom_range(0, 16));
			for (int u = 0; u < 20; u++) begin
				if (u == 10) begin
					hold_pending = 1;
				end
				roll = $urandom_range(99);
				if (roll < 10) begin
					push_noise();
				end else if (roll < 70) begin
					push_motion(1);
				end else if (roll < 85) begin
					push_motion(-1);
				end else begin
					push_motion(0);
				end
			end
		end

		wait_idle();
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
